@@ design/pno_pkg.sv @@
`timescale 1ns / 1ps
// Package for the plane normal orientation block: widths, angle constants,
// the arctangent table and the structs shared by the pipeline cells.
// No dependencies.
package pno_pkg;

  localparam int DEF_COORD_BITS    = 12;
  localparam int DEF_CORDIC_STAGES = 16;
  localparam int TABLE_LEN         = 24;

  localparam int MAG_W  = 30;          // normalized magnitude, leading one at bit 29
  localparam int NS_W   = MAG_W + 1;   // normalized signed component
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = 62;
  localparam int ROOT_W = 31;
  localparam int CW     = 34;          // CORDIC x/y width
  localparam int ZW     = 26;          // angle accumulator, degrees Q16

  localparam int ELEV_W   = 14;
  localparam int AZIM_W   = 15;
  localparam int ELEV_MAX = 5760;
  localparam int AZIM_MAX = 11520;

  localparam int RND_HALF = 512;
  localparam int RND_SH   = 10;

  localparam logic signed [ZW-1:0] DEG90  = ZW'(90 * 65536);
  localparam logic signed [ZW-1:0] DEG180 = ZW'(180 * 65536);

  typedef struct packed {
    logic zero;   // normal is the null vector
    logic vert;   // nx and ny vanish after normalization
  } pno_flags_t;

  typedef struct packed {
    logic                 hold;  // angle already final, no rotation
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } pno_vec_t;

  // round(atan(2^-i) * 180/pi * 65536)
  function automatic logic signed [ZW-1:0] atan_q16(input int unsigned idx);
    logic signed [ZW-1:0] a;
    case (idx)
      0:  a = ZW'(2949120);
      1:  a = ZW'(1740967);
      2:  a = ZW'(919879);
      3:  a = ZW'(466945);
      4:  a = ZW'(234379);
      5:  a = ZW'(117304);
      6:  a = ZW'(58666);
      7:  a = ZW'(29335);
      8:  a = ZW'(14668);
      9:  a = ZW'(7334);
      10: a = ZW'(3667);
      11: a = ZW'(1833);
      12: a = ZW'(917);
      13: a = ZW'(458);
      14: a = ZW'(229);
      15: a = ZW'(115);
      16: a = ZW'(57);
      17: a = ZW'(29);
      18: a = ZW'(14);
      19: a = ZW'(7);
      20: a = ZW'(4);
      21: a = ZW'(2);
      22: a = ZW'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

@@ design/pno_front.sv @@
`timescale 1ns / 1ps
// Front end: edge vectors, cross product, common normalization and the
// squared length of the horizontal part. Eight register stages.
// Depends on pno_pkg.
module pno_front #(
  parameter int COORD_BITS = pno_pkg::DEF_COORD_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic signed [COORD_BITS-1:0]   a_x_i,
  input  logic signed [COORD_BITS-1:0]   a_y_i,
  input  logic signed [COORD_BITS-1:0]   a_z_i,
  input  logic signed [COORD_BITS-1:0]   b_x_i,
  input  logic signed [COORD_BITS-1:0]   b_y_i,
  input  logic signed [COORD_BITS-1:0]   b_z_i,
  input  logic signed [COORD_BITS-1:0]   c_x_i,
  input  logic signed [COORD_BITS-1:0]   c_y_i,
  input  logic signed [COORD_BITS-1:0]   c_z_i,
  output logic                           valid_o,
  output pno_pkg::pno_flags_t            flags_o,
  output logic [pno_pkg::SUM_W-1:0]      sum_o,
  output logic signed [pno_pkg::NS_W-1:0] nx_o,
  output logic signed [pno_pkg::NS_W-1:0] ny_o,
  output logic signed [pno_pkg::NS_W-1:0] nz_o,
  output logic signed [COORD_BITS-1:0]   ref_x_o,
  output logic signed [COORD_BITS-1:0]   ref_y_o,
  output logic signed [COORD_BITS-1:0]   ref_z_o
);
  import pno_pkg::*;

  localparam int DW     = COORD_BITS + 1;
  localparam int PW     = 2 * DW;
  localparam int NW     = PW + 1;
  localparam int LW     = $clog2(NW);
  localparam int TOP    = MAG_W - 1;
  localparam int STAGES = 8;

  logic [STAGES-1:0] vld_q;
  logic signed [COORD_BITS-1:0] rx_q [STAGES];
  logic signed [COORD_BITS-1:0] ry_q [STAGES];
  logic signed [COORD_BITS-1:0] rz_q [STAGES];

  logic signed [DW-1:0] u_q [3];
  logic signed [DW-1:0] v_q [3];
  logic signed [PW-1:0] m_q [6];
  logic signed [NW-1:0] n_q [3];
  logic [NW-1:0]        mg_d [3];
  logic [NW-1:0]        mg4_q [3];
  logic [NW-1:0]        mg5_q [3];
  logic [2:0]           sgn4_q, sgn5_q;
  logic [NW-1:0]        or_q;
  logic                 zero4_q, zero5_q, zero6_q, zero7_q, zero8_q;
  logic [LW-1:0]        msb_d, msb_q;
  logic [NW+MAG_W-1:0]  ext_d [3];
  logic [MAG_W-1:0]     nm_d [3];
  logic [MAG_W-1:0]     mx_q, my_q;
  logic signed [NS_W-1:0] ns6_q [3];
  logic signed [NS_W-1:0] ns7_q [3];
  logic signed [NS_W-1:0] ns8_q [3];
  logic                 vert6_q, vert7_q, vert8_q;
  logic [SQ_W-1:0]      sqx_q, sqy_q;
  logic [SUM_W-1:0]     sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STAGES-2:0], valid_i};
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mg_d[k] = n_q[k][NW-1] ? NW'(-n_q[k]) : NW'(n_q[k]);
    end
  end

  // leading one of the OR equals the leading one of the largest magnitude
  always_comb begin
    msb_d = '0;
    for (int k = 0; k < NW; k++) begin
      if (or_q[k]) msb_d = LW'(k);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (msb_q >= LW'(TOP)) begin
        ext_d[k] = {{MAG_W{1'b0}}, mg5_q[k]} >> (msb_q - LW'(TOP));
      end else begin
        ext_d[k] = {{MAG_W{1'b0}}, mg5_q[k]} << (LW'(TOP) - msb_q);
      end
      nm_d[k] = ext_d[k][MAG_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx_q[0] <= a_x_i;
      ry_q[0] <= a_y_i;
      rz_q[0] <= a_z_i;
      for (int s = 1; s < STAGES; s++) begin
        rx_q[s] <= rx_q[s-1];
        ry_q[s] <= ry_q[s-1];
        rz_q[s] <= rz_q[s-1];
      end
      // edge vectors
      u_q[0] <= DW'(b_x_i) - DW'(a_x_i);
      u_q[1] <= DW'(b_y_i) - DW'(a_y_i);
      u_q[2] <= DW'(b_z_i) - DW'(a_z_i);
      v_q[0] <= DW'(c_x_i) - DW'(a_x_i);
      v_q[1] <= DW'(c_y_i) - DW'(a_y_i);
      v_q[2] <= DW'(c_z_i) - DW'(a_z_i);
      // cross product terms
      m_q[0] <= u_q[1] * v_q[2];
      m_q[1] <= u_q[2] * v_q[1];
      m_q[2] <= u_q[2] * v_q[0];
      m_q[3] <= u_q[0] * v_q[2];
      m_q[4] <= u_q[0] * v_q[1];
      m_q[5] <= u_q[1] * v_q[0];
      n_q[0] <= NW'(m_q[0]) - NW'(m_q[1]);
      n_q[1] <= NW'(m_q[2]) - NW'(m_q[3]);
      n_q[2] <= NW'(m_q[4]) - NW'(m_q[5]);
      // sign and magnitude
      for (int k = 0; k < 3; k++) begin
        mg4_q[k]  <= mg_d[k];
        sgn4_q[k] <= n_q[k][NW-1];
        mg5_q[k]  <= mg4_q[k];
      end
      or_q    <= mg_d[0] | mg_d[1] | mg_d[2];
      zero4_q <= (n_q[0] == '0) && (n_q[1] == '0) && (n_q[2] == '0);
      sgn5_q  <= sgn4_q;
      zero5_q <= zero4_q;
      msb_q   <= msb_d;
      // normalized, signs restored
      for (int k = 0; k < 3; k++) begin
        ns6_q[k] <= sgn5_q[k] ? -NS_W'(nm_d[k]) : NS_W'(nm_d[k]);
        ns7_q[k] <= ns6_q[k];
        ns8_q[k] <= ns7_q[k];
      end
      mx_q    <= nm_d[0];
      my_q    <= nm_d[1];
      vert6_q <= (nm_d[0] == '0) && (nm_d[1] == '0);
      zero6_q <= zero5_q;
      sqx_q   <= mx_q * mx_q;
      sqy_q   <= my_q * my_q;
      vert7_q <= vert6_q;
      zero7_q <= zero6_q;
      sum_q   <= SUM_W'(sqx_q) + SUM_W'(sqy_q);
      vert8_q <= vert7_q;
      zero8_q <= zero7_q;
    end
  end

  assign valid_o      = vld_q[STAGES-1];
  assign flags_o.zero = zero8_q;
  assign flags_o.vert = vert8_q;
  assign sum_o        = sum_q;
  assign nx_o         = ns8_q[0];
  assign ny_o         = ns8_q[1];
  assign nz_o         = ns8_q[2];
  assign ref_x_o      = rx_q[STAGES-1];
  assign ref_y_o      = ry_q[STAGES-1];
  assign ref_z_o      = rz_q[STAGES-1];

endmodule

@@ design/pno_sqrt_cell.sv @@
`timescale 1ns / 1ps
// One digit of the integer square root: decides root bit BIT and
// updates the remainder. Carries a side bus along. Depends on pno_pkg.
module pno_sqrt_cell #(
  parameter int BIT    = 0,
  parameter int SIDE_W = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [pno_pkg::SUM_W-1:0]  rem_i,
  input  logic [pno_pkg::ROOT_W-1:0] root_i,
  input  logic [SIDE_W-1:0]          side_i,
  output logic                       valid_o,
  output logic [pno_pkg::SUM_W-1:0]  rem_o,
  output logic [pno_pkg::ROOT_W-1:0] root_o,
  output logic [SIDE_W-1:0]          side_o
);
  import pno_pkg::*;

  localparam logic [SUM_W-1:0]  ONE_SQ  = SUM_W'(1) << (2 * BIT);
  localparam logic [ROOT_W-1:0] ROOT_BIT = ROOT_W'(1) << BIT;

  logic [SUM_W-1:0]  trial;
  logic              fits;
  logic              valid_q;
  logic [SUM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [SIDE_W-1:0] side_q;

  // (root + 2^b)^2 - root^2
  assign trial = (SUM_W'(root_i) << (BIT + 1)) + ONE_SQ;
  assign fits  = rem_i >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= fits ? rem_i - trial : rem_i;
      root_q <= fits ? (root_i | ROOT_BIT) : root_i;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign side_o  = side_q;

endmodule

@@ design/pno_cordic_cell.sv @@
`timescale 1ns / 1ps
// One CORDIC vectoring step for both angles (elevation and azimuth lanes).
// Depends on pno_pkg.
module pno_cordic_cell #(
  parameter int STAGE  = 0,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  pno_pkg::pno_vec_t el_i,
  input  pno_pkg::pno_vec_t az_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output pno_pkg::pno_vec_t el_o,
  output pno_pkg::pno_vec_t az_o,
  output logic [SIDE_W-1:0] side_o
);
  import pno_pkg::*;

  localparam logic signed [ZW-1:0] ANG = atan_q16(STAGE);

  function automatic pno_vec_t rotate(input pno_vec_t v);
    pno_vec_t             r;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    r  = v;
    xs = $signed(v.x) >>> STAGE;
    ys = $signed(v.y) >>> STAGE;
    if (!v.hold) begin
      if (!v.y[CW-1]) begin
        r.x = v.x + ys;
        r.y = v.y - xs;
        r.z = v.z + ANG;
      end else begin
        r.x = v.x - ys;
        r.y = v.y + xs;
        r.z = v.z - ANG;
      end
    end
    return r;
  endfunction

  logic              valid_q;
  pno_vec_t          el_q, az_q;
  logic [SIDE_W-1:0] side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      el_q   <= rotate(el_i);
      az_q   <= rotate(az_i);
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign el_o    = el_q;
  assign az_o    = az_q;
  assign side_o  = side_q;

endmodule

@@ design/plane_normal_orientation.sv @@
`timescale 1ns / 1ps
// Plane normal orientation: elevation and azimuth of (B-A) x (C-A), deg*64.
// Stages in order: 8 front stages, 31 square root cells, 1 setup stage,
// the CORDIC cells, 1 output register.
// Throughput one transfer per cycle; a stalled output freezes the whole chain.
// Reset clears all valid bits; data registers are not reset.
// Depends on pno_pkg, pno_front, pno_sqrt_cell, pno_cordic_cell.
module plane_normal_orientation #(
  parameter int COORD_BITS    = pno_pkg::DEF_COORD_BITS,
  parameter int CORDIC_STAGES = pno_pkg::DEF_CORDIC_STAGES
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [COORD_BITS-1:0]     a_x_i,
  input  logic signed [COORD_BITS-1:0]     a_y_i,
  input  logic signed [COORD_BITS-1:0]     a_z_i,
  input  logic signed [COORD_BITS-1:0]     b_x_i,
  input  logic signed [COORD_BITS-1:0]     b_y_i,
  input  logic signed [COORD_BITS-1:0]     b_z_i,
  input  logic signed [COORD_BITS-1:0]     c_x_i,
  input  logic signed [COORD_BITS-1:0]     c_y_i,
  input  logic signed [COORD_BITS-1:0]     c_z_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [pno_pkg::ELEV_W-1:0] elevation_o,
  output logic signed [pno_pkg::AZIM_W-1:0] azimuth_o,
  output logic signed [COORD_BITS-1:0]     ref_x_o,
  output logic signed [COORD_BITS-1:0]     ref_y_o,
  output logic signed [COORD_BITS-1:0]     ref_z_o
);
  import pno_pkg::*;

  localparam int NSTG   = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
  localparam int RW3    = 3 * COORD_BITS;
  localparam int SQS_W  = RW3 + 2 + 3 * NS_W;
  localparam int CDS_W  = RW3 + 3;

  logic en;

  // front end
  logic                    fr_valid;
  pno_flags_t              fr_flags;
  logic [SUM_W-1:0]        fr_sum;
  logic signed [NS_W-1:0]  fr_nx, fr_ny, fr_nz;
  logic signed [COORD_BITS-1:0] fr_rx, fr_ry, fr_rz;

  pno_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .a_x_i   (a_x_i),
    .a_y_i   (a_y_i),
    .a_z_i   (a_z_i),
    .b_x_i   (b_x_i),
    .b_y_i   (b_y_i),
    .b_z_i   (b_z_i),
    .c_x_i   (c_x_i),
    .c_y_i   (c_y_i),
    .c_z_i   (c_z_i),
    .valid_o (fr_valid),
    .flags_o (fr_flags),
    .sum_o   (fr_sum),
    .nx_o    (fr_nx),
    .ny_o    (fr_ny),
    .nz_o    (fr_nz),
    .ref_x_o (fr_rx),
    .ref_y_o (fr_ry),
    .ref_z_o (fr_rz)
  );

  // square root chain, one root bit per cell, MSB first
  logic                sq_vld  [ROOT_W+1];
  logic [SUM_W-1:0]    sq_rem  [ROOT_W+1];
  logic [ROOT_W-1:0]   sq_root [ROOT_W+1];
  logic [SQS_W-1:0]    sq_side [ROOT_W+1];

  assign sq_vld[0]  = fr_valid;
  assign sq_rem[0]  = fr_sum;
  assign sq_root[0] = '0;
  assign sq_side[0] = {fr_rx, fr_ry, fr_rz, fr_flags, fr_nx, fr_ny, fr_nz};

  for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
    pno_sqrt_cell #(
      .BIT    (ROOT_W - 1 - g),
      .SIDE_W (SQS_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_vld[g]),
      .rem_i   (sq_rem[g]),
      .root_i  (sq_root[g]),
      .side_i  (sq_side[g]),
      .valid_o (sq_vld[g+1]),
      .rem_o   (sq_rem[g+1]),
      .root_o  (sq_root[g+1]),
      .side_o  (sq_side[g+1])
    );
  end

  logic [RW3-1:0]         s_ref;
  pno_flags_t             s_flags;
  logic signed [NS_W-1:0] s_nx, s_ny, s_nz;

  assign {s_ref, s_flags, s_nx, s_ny, s_nz} = sq_side[ROOT_W];

  // atan2 special cases and half-plane fold ahead of the rotations
  function automatic pno_vec_t prep(input logic signed [CW-1:0] y,
                                    input logic signed [CW-1:0] x);
    pno_vec_t v;
    v.hold = 1'b0;
    v.x    = x;
    v.y    = y;
    v.z    = '0;
    if (y == '0) begin
      v.hold = 1'b1;
      v.z    = (x < 0) ? DEG180 : '0;
    end else if (x == '0) begin
      v.hold = 1'b1;
      v.z    = (y > 0) ? DEG90 : -DEG90;
    end else if (x < 0) begin
      v.x = -x;
      v.y = -y;
      v.z = (y > 0) ? DEG180 : -DEG180;
    end
    return v;
  endfunction

  logic                 cd_vld  [NSTG+1];
  pno_vec_t             cd_el   [NSTG+1];
  pno_vec_t             cd_az   [NSTG+1];
  logic [CDS_W-1:0]     cd_side [NSTG+1];

  logic                 pv_q;
  pno_vec_t             pel_q, paz_q;
  logic [CDS_W-1:0]     pside_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (en) begin
      pv_q <= sq_vld[ROOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pel_q   <= prep(CW'(s_nz), CW'(sq_root[ROOT_W]));
      paz_q   <= prep(CW'(s_ny), CW'(s_nx));
      pside_q <= {s_ref, s_flags, s_nz[NS_W-1]};
    end
  end

  assign cd_vld[0]  = pv_q;
  assign cd_el[0]   = pel_q;
  assign cd_az[0]   = paz_q;
  assign cd_side[0] = pside_q;

  for (genvar g = 0; g < NSTG; g++) begin : g_cordic
    pno_cordic_cell #(
      .STAGE  (g),
      .SIDE_W (CDS_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cd_vld[g]),
      .el_i    (cd_el[g]),
      .az_i    (cd_az[g]),
      .side_i  (cd_side[g]),
      .valid_o (cd_vld[g+1]),
      .el_o    (cd_el[g+1]),
      .az_o    (cd_az[g+1]),
      .side_o  (cd_side[g+1])
    );
  end

  // degrees Q16 to degrees*64, ties away from zero, clamped
  function automatic logic signed [AZIM_W-1:0] to_out(input logic signed [ZW-1:0] q,
                                                      input int lim);
    logic [ZW-1:0] m;
    logic [ZW-1:0] r;
    m = q[ZW-1] ? ZW'(-q) : ZW'(q);
    r = (m + ZW'(RND_HALF)) >> RND_SH;
    if (r > ZW'(lim)) r = ZW'(lim);
    return q[ZW-1] ? -AZIM_W'(r) : AZIM_W'(r);
  endfunction

  logic [RW3-1:0] c_ref;
  pno_flags_t     c_flags;
  logic           c_nzneg;

  assign {c_ref, c_flags, c_nzneg} = cd_side[NSTG];

  logic                       out_valid_q;
  logic signed [ELEV_W-1:0]   elev_q;
  logic signed [AZIM_W-1:0]   azim_q;
  logic [RW3-1:0]             ref_q;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign en         = ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= cd_vld[NSTG];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ref_q <= c_ref;
      if (c_flags.zero) begin
        elev_q <= '0;
        azim_q <= '0;
      end else if (c_flags.vert) begin
        elev_q <= c_nzneg ? -ELEV_W'(ELEV_MAX) : ELEV_W'(ELEV_MAX);
        azim_q <= '0;
      end else begin
        elev_q <= ELEV_W'(to_out(cd_el[NSTG].z, ELEV_MAX));
        azim_q <= to_out(cd_az[NSTG].z, AZIM_MAX);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign elevation_o = elev_q;
  assign azimuth_o   = azim_q;
  assign ref_x_o     = ref_q[RW3-1 -: COORD_BITS];
  assign ref_y_o     = ref_q[2*COORD_BITS-1 -: COORD_BITS];
  assign ref_z_o     = ref_q[COORD_BITS-1:0];

  a_elev_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (elevation_o <= $signed(ELEV_W'(ELEV_MAX))) &&
                    (elevation_o >= -$signed(ELEV_W'(ELEV_MAX))))
    else $error("elevation out of range");

  a_azim_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (azimuth_o <= $signed(AZIM_W'(AZIM_MAX))) &&
                    (azimuth_o >= -$signed(AZIM_W'(AZIM_MAX))))
    else $error("azimuth out of range");

  a_rise_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_stall_o))
    else $error("output appeared while the chain was frozen");

endmodule

@@ tb/pno_checker.sv @@
`timescale 1ns / 1ps
// Checker for plane_normal_orientation: watches both channels, predicts the
// normal angles and reference point of each transfer and compares them in order. Uses pno_pkg.
module pno_checker #(
  parameter int COORD_BITS    = 12,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic signed [COORD_BITS-1:0]      a_x_i,
  input  logic signed [COORD_BITS-1:0]      a_y_i,
  input  logic signed [COORD_BITS-1:0]      a_z_i,
  input  logic signed [COORD_BITS-1:0]      b_x_i,
  input  logic signed [COORD_BITS-1:0]      b_y_i,
  input  logic signed [COORD_BITS-1:0]      b_z_i,
  input  logic signed [COORD_BITS-1:0]      c_x_i,
  input  logic signed [COORD_BITS-1:0]      c_y_i,
  input  logic signed [COORD_BITS-1:0]      c_z_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic signed [pno_pkg::ELEV_W-1:0] elevation_i,
  input  logic signed [pno_pkg::AZIM_W-1:0] azimuth_i,
  input  logic signed [COORD_BITS-1:0]      ref_x_i,
  input  logic signed [COORD_BITS-1:0]      ref_y_i,
  input  logic signed [COORD_BITS-1:0]      ref_z_i,
  output int                                errors_o,
  output int                                pending_o
);
  import pno_pkg::*;

  typedef struct {
    logic signed [ELEV_W-1:0]     elev;
    logic signed [AZIM_W-1:0]     azim;
    logic signed [COORD_BITS-1:0] rx;
    logic signed [COORD_BITS-1:0] ry;
    logic signed [COORD_BITS-1:0] rz;
  } angles_t;

  angles_t angle_q[$];

  localparam longint ATAN_TBL [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

  function automatic longint unsigned root64(input longint unsigned s);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s   = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // vectoring rotation, x >= 0; degrees Q16
  function automatic longint rotate_angle(input longint x, input longint y);
    longint z, xn, yn;
    int n;
    z = 0;
    n = CORDIC_STAGES < 24 ? CORDIC_STAGES : 24;
    for (int i = 0; i < n; i++) begin
      if (y >= 0) begin
        xn = x + (y >>> i);
        yn = y - (x >>> i);
        z  = z + ATAN_TBL[i];
      end else begin
        xn = x - (y >>> i);
        yn = y + (x >>> i);
        z  = z - ATAN_TBL[i];
      end
      x = xn;
      y = yn;
    end
    return z;
  endfunction

  function automatic longint arctan2_q16(input longint y, input longint x);
    if (y == 0) return x < 0 ? 180 * 65536 : 0;
    if (x == 0) return y > 0 ? 90 * 65536 : -90 * 65536;
    if (x < 0) return (y > 0 ? 180 * 65536 : -180 * 65536) + rotate_angle(-x, -y);
    return rotate_angle(x, y);
  endfunction

  function automatic longint round_deg64(input longint q, input longint lim);
    longint r;
    r = q >= 0 ? (q + 512) >>> 10 : -((-q + 512) >>> 10);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic longint scale_mag(input longint v, input int sh);
    longint m;
    m = v < 0 ? -v : v;
    if (sh > 0) m = m << sh;
    else if (sh < 0) m = m >> (-sh);
    return v < 0 ? -m : m;
  endfunction

  function automatic angles_t predict_angles(
      input longint ax, input longint ay, input longint az,
      input longint bx, input longint by, input longint bz,
      input longint cx, input longint cy, input longint cz);
    angles_t r;
    longint ux, uy, uz, vx, vy, vz, nx, ny, nz, m, el, az_o, rt;
    int sh;
    ux = bx - ax; uy = by - ay; uz = bz - az;
    vx = cx - ax; vy = cy - ay; vz = cz - az;
    nx = uy * vz - uz * vy;
    ny = uz * vx - ux * vz;
    nz = ux * vy - uy * vx;
    el = 0;
    az_o = 0;
    if (nx != 0 || ny != 0 || nz != 0) begin
      m = nx < 0 ? -nx : nx;
      if ((ny < 0 ? -ny : ny) > m) m = ny < 0 ? -ny : ny;
      if ((nz < 0 ? -nz : nz) > m) m = nz < 0 ? -nz : nz;
      sh = 0;
      while (m >= (64'sd1 << 30)) begin m = m >> 1; sh--; end
      while (m < (64'sd1 << 29)) begin m = m << 1; sh++; end
      nx = scale_mag(nx, sh);
      ny = scale_mag(ny, sh);
      nz = scale_mag(nz, sh);
      if (nx == 0 && ny == 0) begin
        el = nz > 0 ? ELEV_MAX : -ELEV_MAX;
      end else begin
        rt   = longint'(root64(longint'(nx * nx) + longint'(ny * ny)));
        el   = round_deg64(arctan2_q16(nz, rt), ELEV_MAX);
        az_o = round_deg64(arctan2_q16(ny, nx), AZIM_MAX);
      end
    end
    r.elev = el[ELEV_W-1:0];
    r.azim = az_o[AZIM_W-1:0];
    r.rx = ax[COORD_BITS-1:0];
    r.ry = ay[COORD_BITS-1:0];
    r.rz = az[COORD_BITS-1:0];
    return r;
  endfunction

  int err_q  = 0;
  int pend_q = 0;

  assign errors_o  = err_q;
  assign pending_o = pend_q;

  always @(posedge clk_i) begin
    angles_t exp_a;
    int      n_err;
    n_err = 0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i)
        angle_q.push_back(predict_angles(a_x_i, a_y_i, a_z_i, b_x_i, b_y_i, b_z_i,
                                         c_x_i, c_y_i, c_z_i));
      if (out_valid_i && !out_stall_i) begin
        if (angle_q.size() == 0) begin
          $error("result transfer with no pending expectation");
          n_err++;
        end else begin
          exp_a = angle_q.pop_front();
          if (elevation_i !== exp_a.elev) begin
            $error("elevation: expected %0d actual %0d", exp_a.elev, elevation_i);
            n_err++;
          end
          if (azimuth_i !== exp_a.azim) begin
            $error("azimuth: expected %0d actual %0d", exp_a.azim, azimuth_i);
            n_err++;
          end
          if (ref_x_i !== exp_a.rx) begin
            $error("ref_x: expected %0d actual %0d", exp_a.rx, ref_x_i);
            n_err++;
          end
          if (ref_y_i !== exp_a.ry) begin
            $error("ref_y: expected %0d actual %0d", exp_a.ry, ref_y_i);
            n_err++;
          end
          if (ref_z_i !== exp_a.rz) begin
            $error("ref_z: expected %0d actual %0d", exp_a.rz, ref_z_i);
            n_err++;
          end
        end
      end
    end
    err_q  <= err_q + n_err;
    pend_q <= angle_q.size();
  end

endmodule

@@ tb/plane_normal_orientation_tb.sv @@
`timescale 1ns / 1ps
// Top of the plane_normal_orientation bench: clock, reset, point triples and
// output stall; pno_checker does prediction and compare. Uses pno_pkg.
module plane_normal_orientation_tb;
  import pno_pkg::*;

  localparam int CB = 12;
  localparam int N_RAND = 1100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CB-1:0] pt [9] = '{default: '0};
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [ELEV_W-1:0] elevation;
  logic signed [AZIM_W-1:0] azimuth;
  logic signed [CB-1:0] ref_x, ref_y, ref_z;
  int errors, pending;
  int sent = 0;
  bit quiet = 1'b0;   // no idling in the closing part

  initial forever #1 clk = ~clk;

  plane_normal_orientation u_dut (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .a_x_i(pt[0]), .a_y_i(pt[1]), .a_z_i(pt[2]),
    .b_x_i(pt[3]), .b_y_i(pt[4]), .b_z_i(pt[5]),
    .c_x_i(pt[6]), .c_y_i(pt[7]), .c_z_i(pt[8]),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .elevation_o(elevation), .azimuth_o(azimuth),
    .ref_x_o(ref_x), .ref_y_o(ref_y), .ref_z_o(ref_z));

  pno_checker u_chk (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_i(in_stall),
    .a_x_i(pt[0]), .a_y_i(pt[1]), .a_z_i(pt[2]),
    .b_x_i(pt[3]), .b_y_i(pt[4]), .b_z_i(pt[5]),
    .c_x_i(pt[6]), .c_y_i(pt[7]), .c_z_i(pt[8]),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .elevation_i(elevation), .azimuth_i(azimuth),
    .ref_x_i(ref_x), .ref_y_i(ref_y), .ref_z_i(ref_z),
    .errors_o(errors), .pending_o(pending));

  // one transfer; called at a falling edge, returns at a falling edge
  task automatic send_triple(input int p [9]);
    for (int i = 0; i < 9; i++) pt[i] <= CB'(p[i]);
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent++;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
  endtask

  function automatic int rand_coord(input int mode);
    case (mode)
      0: return $urandom_range(0, 4095) - 2048;
      1: return $urandom_range(0, 15) - 8;
      default: return $urandom_range(0, 1) ? 2047 : -2048;
    endcase
  endfunction

  // receiver: random stall bursts, one long hold-off, none at the end
  initial begin
    int hold;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (quiet) begin
        out_stall <= 1'b0;
      end else if (sent >= 300 && sent < 310) begin
        out_stall <= 1'b1;
        hold = 0;
        while (hold < 200) begin @(negedge clk); hold++; end
        out_stall <= 1'b0;
        wait (sent >= 310);
      end else if ($urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int p [9];
    int mode, k;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // degenerate: coincident points, then collinear
    send_triple('{0, 0, 0, 0, 0, 0, 0, 0, 0});
    send_triple('{1, 1, 1, 2, 2, 2, 3, 3, 3});
    // vertical normal, up and down
    send_triple('{0, 0, 0, 1, 0, 0, 0, 1, 0});
    send_triple('{0, 0, 0, 0, 1, 0, 1, 0, 0});
    // ny zero with nx positive and negative
    send_triple('{0, 0, 0, 0, 1, 0, 0, 0, 1});
    send_triple('{0, 0, 0, 0, 0, 1, 0, 1, 0});
    // positive nx and ny with nz of both signs
    send_triple('{0, 0, 0, 0, 5, 1, 3, 0, 2});
    send_triple('{0, 0, 0, 0, -5, 1, 3, 0, -2});
    // azimuth of +-90 degrees
    send_triple('{0, 0, 0, 0, 0, 1, 1, 0, 0});
    send_triple('{0, 0, 0, 1, 0, 0, 0, 0, 1});
    // extremes of the coordinates
    send_triple('{-2048, -2048, -2048, 2047, -2048, -2048, -2048, 2047, -2048});
    send_triple('{2047, 2047, 2047, -2048, 2047, 2047, 2047, -2048, 2047});
    send_triple('{-2048, 2047, -2048, 2047, -2048, 2047, -2048, -2048, 2047});
    send_triple('{2047, -2048, 2047, -2048, 2047, 2047, -2048, -2048, -2048});
    send_triple('{-2048, -2048, 0, 2047, 2047, 0, 2047, -2048, 2047});
    send_triple('{2047, 0, -2048, 0, 2047, -2048, -2048, -2048, 2047});
    for (int n = 0; n < N_RAND; n++) begin
      if (n == 500) begin
        in_valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
      end
      if (n == N_RAND - 150) quiet = 1'b1;
      k = $urandom_range(0, 9);
      mode = k < 6 ? 0 : (k < 8 ? 1 : 2);
      for (int i = 0; i < 9; i++) p[i] = rand_coord(k == 9 ? $urandom_range(0, 2) : mode);
      if ($urandom_range(0, 19) == 0) begin
        // collinear: C = A + 2*(B - A)
        for (int i = 0; i < 3; i++) begin
          p[i]   = rand_coord(1) * 64;
          p[i+3] = p[i] + rand_coord(1) * 32;
          p[i+6] = 2 * p[i+3] - p[i];
        end
      end
      send_triple(p);
    end
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (80) @(posedge clk);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ files.f @@
design/pno_pkg.sv
design/pno_front.sv
design/pno_sqrt_cell.sv
design/pno_cordic_cell.sv
design/plane_normal_orientation.sv
tb/pno_checker.sv
tb/plane_normal_orientation_tb.sv
